[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`endif
`endif

[rtl/nnsa_pkg.sv]
// ----------------------------------------------------------------------------
// nnsa_pkg
// Widths, register indexes, pipeline types and helpers for the
// nearest-neighbor scale address generator.
// ----------------------------------------------------------------------------
package nnsa_pkg;

  localparam int DIM_W      = 13;
  localparam int COORD_W    = 12;
  localparam int INDEX_W    = 24;
  localparam int NUM_W      = 2 * COORD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_STAGES = COORD_W;
  // input reg, product reg, divider stages, resolve, multiply, add
  localparam int PIPE_LAT   = DIV_STAGES + 5;

  localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(4096);
  localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = CFG_IDX_W'(3);

  typedef enum logic [1:0] {
    MAP_ZERO,
    MAP_SAT,
    MAP_DIV
  } map_mode_t;

  // per-word side data that rides alongside the dividers
  typedef struct packed {
    map_mode_t          col_mode;
    map_mode_t          row_mode;
    logic [INDEX_W-1:0] dst_index;
  } side_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    d = v;
    if (v == '0) d = DIM_ONE;
    else if (v > MAX_DIM) d = MAX_DIM;
    return d;
  endfunction

  // dim of one has no divide; pos at or past the last column or row pins to the edge
  function automatic map_mode_t map_mode(input logic [COORD_W-1:0] pos,
                                         input logic [DIM_W-1:0]   dim,
                                         input logic [COORD_W-1:0] dim_m1);
    map_mode_t m;
    if (dim <= DIM_ONE) m = MAP_ZERO;
    else if (pos >= dim_m1) m = MAP_SAT;
    else m = MAP_DIV;
    return m;
  endfunction

  function automatic logic [COORD_W-1:0] resolve(input map_mode_t m,
                                                 input logic [COORD_W-1:0] quo,
                                                 input logic [COORD_W-1:0] edge_val);
    logic [COORD_W-1:0] r;
    case (m)
      MAP_ZERO: r = '0;
      MAP_SAT:  r = edge_val;
      MAP_DIV:  r = quo;
      default:  r = quo;
    endcase
    return r;
  endfunction

endpackage

[rtl/nnsa_div.sv]
// ----------------------------------------------------------------------------
// nnsa_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees the quotient fits COORD_W bits (upper numerator half < divisor).
// ----------------------------------------------------------------------------
module nnsa_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [nnsa_pkg::NUM_W-1:0]   in_num,
  input  logic [nnsa_pkg::COORD_W-1:0] in_divisor,
  output logic                         out_valid,
  output logic [nnsa_pkg::COORD_W-1:0] out_quo
);
  import nnsa_pkg::*;

  logic               vld_r [DIV_STAGES];
  logic [COORD_W-1:0] rem_r [DIV_STAGES];
  logic [COORD_W-1:0] low_r [DIV_STAGES];
  logic [COORD_W-1:0] quo_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic               vld_in;
    logic [COORD_W-1:0] rem_in;
    logic [COORD_W-1:0] low_in;
    logic [COORD_W-1:0] quo_in;
    logic [COORD_W:0]   trial;
    logic [COORD_W:0]   diff;
    logic               ge;

    if (k == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = in_num[NUM_W-1:COORD_W];
      assign low_in = in_num[COORD_W-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = {rem_in, low_in[COORD_W-1]};
    assign diff  = trial - {1'b0, in_divisor};
    assign ge    = (trial >= {1'b0, in_divisor});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
      low_r[k] <= {low_in[COORD_W-2:0], 1'b0};
      quo_r[k] <= {quo_in[COORD_W-2:0], ge};
    end
  end

  assign out_valid = vld_r[DIV_STAGES-1];
  assign out_quo   = quo_r[DIV_STAGES-1];

endmodule

[rtl/nearest_neighbor_scale_address_top.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_address_top
// Maps a destination pixel to its nearest source pixel and returns both
// coordinates plus the source and destination linear indexes.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  input     start & !busy          in_dst_col, in_dst_row
//  result    out_strobe (1 cycle)   out_src_col, out_src_row,
//                                   out_src_index, out_dst_index
//  config    cfg_we                 cfg_index, cfg_wdata
//
//  One word is taken every cycle; busy stays low.
//  Pipeline: input reg, multiply, 12 divider stages (one quotient bit
//  each, set by the col/row dividers), resolve, multiply, add.
//  Synchronous active-low reset clears the valid chain and sets all
//  dimensions to 1. Results go out on a one-cycle strobe; the receiver
//  cannot stall, so nothing in the pipe ever waits.
//
`include "assert_macros.svh"

module nearest_neighbor_scale_address_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [nnsa_pkg::COORD_W-1:0]   in_dst_col,
  input  logic [nnsa_pkg::COORD_W-1:0]   in_dst_row,
  output logic                           out_strobe,
  output logic [nnsa_pkg::COORD_W-1:0]   out_src_col,
  output logic [nnsa_pkg::COORD_W-1:0]   out_src_row,
  output logic [nnsa_pkg::INDEX_W-1:0]   out_src_index,
  output logic [nnsa_pkg::INDEX_W-1:0]   out_dst_index,
  input  logic                           cfg_we,
  input  logic [nnsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nnsa_pkg::DIM_W-1:0]     cfg_wdata
);
  import nnsa_pkg::*;

  // config, stored as effective dimensions
  logic [DIM_W-1:0]   src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [COORD_W-1:0] sw_m1, sh_m1, dw_m1, dh_m1;
  logic [2*DIM_W-1:0] dst_area;
  logic [INDEX_W-1:0] dst_last_nxt, dst_last_r;

  logic               accept;
  logic               v0_r, v1_r, v14_r, v15_r, out_strobe_r;
  logic [COORD_W-1:0] col0_r, row0_r, dcol1_r;
  logic [NUM_W-1:0]   ncol_r, nrow_r;
  logic [INDEX_W-1:0] dprod_r;
  map_mode_t          cmode1_r, rmode1_r;
  side_t              side_r [DIV_STAGES];
  logic [INDEX_W-1:0] dsum_nxt, dclamp_nxt;

  logic               div_col_v, div_row_v;
  logic [COORD_W-1:0] div_col_q, div_row_q;

  logic [COORD_W-1:0] sc14_r, sr14_r, sc15_r, sr15_r;
  logic [INDEX_W-1:0] di14_r, di15_r, sprod_r;
  logic [INDEX_W-1:0] sidx_nxt;
  logic [COORD_W-1:0] out_src_col_r, out_src_row_r;
  logic [INDEX_W-1:0] out_src_index_r, out_dst_index_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // -------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= DIM_ONE;
      src_h_r <= DIM_ONE;
      dst_w_r <= DIM_ONE;
      dst_h_r <= DIM_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_w_r <= eff_dim(cfg_wdata);
        REG_SRC_HEIGHT: src_h_r <= eff_dim(cfg_wdata);
        REG_DST_WIDTH:  dst_w_r <= eff_dim(cfg_wdata);
        REG_DST_HEIGHT: dst_h_r <= eff_dim(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign sw_m1 = COORD_W'(src_w_r - DIM_ONE);
  assign sh_m1 = COORD_W'(src_h_r - DIM_ONE);
  assign dw_m1 = COORD_W'(dst_w_r - DIM_ONE);
  assign dh_m1 = COORD_W'(dst_h_r - DIM_ONE);

  // last destination pixel; read only at the side_r[0] clamp, behind the input
  // and product registers, so the lag of its register after a write never shows
  assign dst_area     = (2*DIM_W)'(dst_w_r) * (2*DIM_W)'(dst_h_r);
  assign dst_last_nxt = INDEX_W'(dst_area - (2*DIM_W)'(1));

  always_ff @(posedge clk) begin
    dst_last_r <= dst_last_nxt;
  end

  // -------------------------------------------------------------- valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r         <= 1'b0;
      v1_r         <= 1'b0;
      v14_r        <= 1'b0;
      v15_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      v0_r         <= accept;
      v1_r         <= v0_r;
      v14_r        <= div_col_v & div_row_v;
      v15_r        <= v14_r;
      out_strobe_r <= v15_r;
    end
  end

  // -------------------------------------------------------------- front
  always_ff @(posedge clk) begin
    col0_r   <= in_dst_col;
    row0_r   <= in_dst_row;
    ncol_r   <= NUM_W'(col0_r) * NUM_W'(sw_m1);
    nrow_r   <= NUM_W'(row0_r) * NUM_W'(sh_m1);
    dprod_r  <= INDEX_W'(row0_r) * INDEX_W'(dst_w_r);
    dcol1_r  <= col0_r;
    cmode1_r <= map_mode(col0_r, dst_w_r, dw_m1);
    rmode1_r <= map_mode(row0_r, dst_h_r, dh_m1);
  end

  assign dsum_nxt   = INDEX_W'(dcol1_r) + dprod_r;
  assign dclamp_nxt = (side_r[0].dst_index > dst_last_r) ? dst_last_r
                                                         : side_r[0].dst_index;

  // side data tracks the divider stages one for one
  always_ff @(posedge clk) begin
    side_r[0].col_mode  <= cmode1_r;
    side_r[0].row_mode  <= rmode1_r;
    side_r[0].dst_index <= dsum_nxt;
    side_r[1].col_mode  <= side_r[0].col_mode;
    side_r[1].row_mode  <= side_r[0].row_mode;
    side_r[1].dst_index <= dclamp_nxt;
    for (int k = 2; k < DIV_STAGES; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // -------------------------------------------------------------- divide
  nnsa_div u_div_col (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (v1_r),
    .in_num     (ncol_r),
    .in_divisor (dw_m1),
    .out_valid  (div_col_v),
    .out_quo    (div_col_q)
  );

  nnsa_div u_div_row (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (v1_r),
    .in_num     (nrow_r),
    .in_divisor (dh_m1),
    .out_valid  (div_row_v),
    .out_quo    (div_row_q)
  );

  // -------------------------------------------------------------- back
  // src coords never pass the last row/col, so the source index needs no clamp
  assign sidx_nxt = INDEX_W'(sc15_r) + sprod_r;

  always_ff @(posedge clk) begin
    sc14_r          <= resolve(side_r[DIV_STAGES-1].col_mode, div_col_q, sw_m1);
    sr14_r          <= resolve(side_r[DIV_STAGES-1].row_mode, div_row_q, sh_m1);
    di14_r          <= side_r[DIV_STAGES-1].dst_index;
    sc15_r          <= sc14_r;
    sr15_r          <= sr14_r;
    sprod_r         <= INDEX_W'(sr14_r) * INDEX_W'(src_w_r);
    di15_r          <= di14_r;
    out_src_col_r   <= sc15_r;
    out_src_row_r   <= sr15_r;
    out_src_index_r <= sidx_nxt;
    out_dst_index_r <= di15_r;
  end

  assign out_strobe    = out_strobe_r;
  assign out_src_col   = out_src_col_r;
  assign out_src_row   = out_src_row_r;
  assign out_src_index = out_src_index_r;
  assign out_dst_index = out_dst_index_r;

  // -------------------------------------------------------------- checks
  `ASSERT_IMPLIES(a_word_out, clk, rst_n, accept, ##PIPE_LAT out_strobe,
                  "accepted word did not come out at pipeline latency")
  `ASSERT_IMPLIES(a_no_phantom, clk, rst_n, out_strobe, $past(accept, PIPE_LAT),
                  "result strobe without a matching accepted word")
  `ASSERT_ALWAYS(a_div_sync, clk, rst_n, div_col_v == div_row_v,
                 "column and row dividers out of step")
  `ASSERT_IMPLIES(a_src_range, clk, rst_n, out_strobe,
                  (out_src_col <= sw_m1 && out_src_row <= sh_m1),
                  "source coordinate past image edge")
  `ASSERT_IMPLIES(a_dst_range, clk, rst_n, out_strobe, out_dst_index <= dst_last_r,
                  "destination index past last pixel")

endmodule

[verif/nearest_neighbor_scale_address_top_tb.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_address_top_tb
// Drives destination pixel coordinates through the nearest-neighbor address
// generator under a range of image sizes and sender gaps. Every result word
// is checked against a behavioral prediction of the mapping: scaled source
// coordinates, the clamped source index and the clamped destination index.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_address_top_tb;
  import nnsa_pkg::*;

  typedef struct {
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    logic [INDEX_W-1:0] src_index;
    logic [INDEX_W-1:0] dst_index;
  } pixel_addr_t;

  localparam int MAX_SIZE  = 4096;
  localparam int RAND_WORDS = 75;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [COORD_W-1:0]   in_dst_col = '0;
  logic [COORD_W-1:0]   in_dst_row = '0;
  logic                 out_strobe;
  logic [COORD_W-1:0]   out_src_col;
  logic [COORD_W-1:0]   out_src_row;
  logic [INDEX_W-1:0]   out_src_index;
  logic [INDEX_W-1:0]   out_dst_index;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_wdata = '0;

  // shadow copy of the dimension registers
  logic [DIM_W-1:0] src_width_reg = DIM_W'(1);
  logic [DIM_W-1:0] src_height_reg = DIM_W'(1);
  logic [DIM_W-1:0] dst_width_reg = DIM_W'(1);
  logic [DIM_W-1:0] dst_height_reg = DIM_W'(1);

  pixel_addr_t expected_addr_q[$];
  int          mismatch_count = 0;
  int          idle_pct = 0;

  nearest_neighbor_scale_address_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_dst_col   (in_dst_col),
    .in_dst_row   (in_dst_row),
    .out_strobe   (out_strobe),
    .out_src_col  (out_src_col),
    .out_src_row  (out_src_row),
    .out_src_index(out_src_index),
    .out_dst_index(out_dst_index),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned effective_dim(input logic [DIM_W-1:0] v);
    longint unsigned d;
    d = 64'(v);
    if (d == 0) d = 1;
    if (d > MAX_SIZE) d = MAX_SIZE;
    return d;
  endfunction

  function automatic longint unsigned scaled_coord(input longint unsigned pos,
                                                   input longint unsigned src_dim,
                                                   input longint unsigned dst_dim);
    longint unsigned q;
    if (dst_dim <= 1) return 0;
    q = (pos * (src_dim - 1)) / (dst_dim - 1);
    if (q > src_dim - 1) q = src_dim - 1;
    return q;
  endfunction

  function automatic longint unsigned clamped_index(input longint unsigned c,
                                                    input longint unsigned r,
                                                    input longint unsigned w,
                                                    input longint unsigned h);
    longint unsigned idx;
    idx = c + r * w;
    if (idx > w * h - 1) idx = w * h - 1;
    return idx;
  endfunction

  function automatic pixel_addr_t predict_addr(input logic [COORD_W-1:0] col,
                                               input logic [COORD_W-1:0] row);
    longint unsigned sw, sh, dw, dh, sc, sr;
    pixel_addr_t     a;
    sw = effective_dim(src_width_reg);
    sh = effective_dim(src_height_reg);
    dw = effective_dim(dst_width_reg);
    dh = effective_dim(dst_height_reg);
    sc = scaled_coord(64'(col), sw, dw);
    sr = scaled_coord(64'(row), sh, dh);
    a.src_col   = COORD_W'(sc);
    a.src_row   = COORD_W'(sr);
    a.src_index = INDEX_W'(clamped_index(sc, sr, sw, sh));
    a.dst_index = INDEX_W'(clamped_index(64'(col), 64'(row), dw, dh));
    return a;
  endfunction

  // mostly inside the destination image, with edges and out-of-range values
  function automatic logic [COORD_W-1:0] pick_coord(input longint unsigned dim);
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      6:       return COORD_W'(dim - 1);
      7:       return '0;
      8:       return COORD_W'($urandom_range(MAX_SIZE - 1, int'(dim) - 1));
      9:       return COORD_W'($urandom_range(0, MAX_SIZE - 1));
      default: return COORD_W'($urandom_range(0, int'(dim) - 1));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return '0;
      1:       return DIM_W'(1);
      2:       return DIM_W'(2);
      3:       return DIM_W'($urandom_range(3, 64));
      4:       return DIM_W'(MAX_SIZE);
      5:       return DIM_W'($urandom_range(MAX_SIZE + 1, 2 ** DIM_W - 1));
      6:       return DIM_W'($urandom_range(0, 2 ** DIM_W - 1));
      default: return DIM_W'($urandom_range(1, MAX_SIZE));
    endcase
  endfunction

  // result checker: one word per strobe, compared with the oldest prediction
  always @(posedge clk) begin
    pixel_addr_t want;
    if (rst_n && out_strobe) begin
      if (expected_addr_q.size() == 0) begin
        $error("result word with none expected: src_col %0d src_row %0d",
               out_src_col, out_src_row);
        mismatch_count++;
      end else begin
        want = expected_addr_q.pop_front();
        if (out_src_col !== want.src_col) begin
          $error("src_col: expected %0d, actual %0d", want.src_col, out_src_col);
          mismatch_count++;
        end
        if (out_src_row !== want.src_row) begin
          $error("src_row: expected %0d, actual %0d", want.src_row, out_src_row);
          mismatch_count++;
        end
        if (out_src_index !== want.src_index) begin
          $error("src_index: expected %0d, actual %0d", want.src_index, out_src_index);
          mismatch_count++;
        end
        if (out_dst_index !== want.dst_index) begin
          $error("dst_index: expected %0d, actual %0d", want.dst_index, out_dst_index);
          mismatch_count++;
        end
      end
    end
  end

  // leaves start high so back-to-back words follow with no idle gap
  task automatic send_pixel(input logic [COORD_W-1:0] col,
                            input logic [COORD_W-1:0] row);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_dst_col = col;
    in_dst_row = row;
    do @(posedge clk); while (busy);
    expected_addr_q.push_back(predict_addr(col, row));
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (expected_addr_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_dim(input logic [CFG_IDX_W-1:0] idx,
                           input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      REG_SRC_WIDTH:  src_width_reg = val;
      REG_SRC_HEIGHT: src_height_reg = val;
      REG_DST_WIDTH:  dst_width_reg = val;
      REG_DST_HEIGHT: dst_height_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all_dims(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                                input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh);
    write_dim(REG_SRC_WIDTH, sw);
    write_dim(REG_SRC_HEIGHT, sh);
    write_dim(REG_DST_WIDTH, dw);
    write_dim(REG_DST_HEIGHT, dh);
  endtask

  // all dimensions are 1 out of reset
  task automatic test_reset_dims();
    send_pixel('0, '0);
    send_pixel('1, '1);
    send_pixel(COORD_W'(1), '0);
    drain_results();
  endtask

  // zero acts as one, oversized values pin to the max, unknown indexes ignored
  task automatic test_register_extremes();
    write_all_dims('0, '1, DIM_W'(MAX_SIZE + 1), '0);
    send_pixel('0, '0);
    send_pixel('1, '1);
    send_pixel(COORD_W'(2048), COORD_W'(7));
    drain_results();
    for (int i = int'(REG_DST_HEIGHT) + 1; i < 2 ** CFG_IDX_W; i++)
      write_dim(CFG_IDX_W'(i), '1);
    send_pixel(COORD_W'(100), COORD_W'(3));
    drain_results();
    write_all_dims(DIM_W'(MAX_SIZE), DIM_W'(MAX_SIZE), DIM_W'(MAX_SIZE),
                   DIM_W'(MAX_SIZE));
    send_pixel('1, '1);
    send_pixel('0, '1);
    send_pixel(COORD_W'(12'haaa), COORD_W'(12'h555));
    drain_results();
  endtask

  // upscale, coordinates past the edge, single-column destination
  task automatic test_directed_mapping();
    write_all_dims(DIM_W'(640), DIM_W'(480), DIM_W'(1920), DIM_W'(1080));
    send_pixel('0, '0);
    send_pixel(COORD_W'(1), COORD_W'(1));
    send_pixel(COORD_W'(1918), COORD_W'(1078));
    send_pixel(COORD_W'(1919), COORD_W'(1079));
    send_pixel(COORD_W'(1920), COORD_W'(1080));
    send_pixel('1, '0);
    drain_results();
    write_dim(REG_DST_WIDTH, DIM_W'(1));
    send_pixel(COORD_W'(5), COORD_W'(3));
    send_pixel('0, COORD_W'(1079));
    drain_results();
    write_all_dims(DIM_W'(3), DIM_W'(2), DIM_W'(7), DIM_W'(5));
    send_pixel(COORD_W'(3), COORD_W'(2));
    send_pixel(COORD_W'(6), COORD_W'(4));
    drain_results();
  endtask

  // mostly random sizes per setting, three gap phases
  task automatic test_random_scaling();
    int               gap_pct[3] = '{0, 58, 13};
    longint unsigned  dw, dh;
    for (int p = 0; p < 3; p++) begin
      for (int s = 0; s < 4; s++) begin
        drain_results();
        idle_pct = gap_pct[p];
        if (p == 0 && s == 0)
          write_all_dims(DIM_W'(MAX_SIZE), DIM_W'(MAX_SIZE), pick_dim(), pick_dim());
        else if (p == 1 && s == 0)
          write_all_dims(DIM_W'(1), DIM_W'(1), DIM_W'(MAX_SIZE), DIM_W'(MAX_SIZE));
        else
          write_all_dims(pick_dim(), pick_dim(), pick_dim(), pick_dim());
        if ($urandom_range(0, 3) == 0)
          write_dim(CFG_IDX_W'($urandom_range(int'(REG_DST_HEIGHT) + 1,
                                              2 ** CFG_IDX_W - 1)),
                    DIM_W'($urandom_range(0, 2 ** DIM_W - 1)));
        dw = effective_dim(dst_width_reg);
        dh = effective_dim(dst_height_reg);
        for (int n = 0; n < RAND_WORDS; n++)
          send_pixel(pick_coord(dw), pick_coord(dh));
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_dims();
    test_register_extremes();
    test_directed_mapping();
    test_random_scaling();
    drain_results();
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    repeat (200000) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/nnsa_pkg.sv
rtl/nnsa_div.sv
rtl/nearest_neighbor_scale_address_top.sv
verif/nearest_neighbor_scale_address_top_tb.sv
